### sv/assert_macros.svh
// Assertion helper macros for the ring FIFO statistics core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked property check, disabled while reset is asserted (active low)
`define RFS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked check that a condition never holds
`define RFS_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define RFS_ASSERT(label, clk, rst_n, prop)
`define RFS_NEVER(label, clk, rst_n, cond)

`endif

`endif

### sv/rfs_pkg.sv
// Shared constants, codes and control structs for the ring FIFO statistics core.
// No dependencies.
`default_nettype none

package rfs_pkg;

    // Slot count of the ring; one slot stays empty, so the queue holds DEPTH-1 words
    localparam int DEPTH     = 16;
    localparam int NUM_CELLS = DEPTH - 1;

    // Field widths
    localparam int ACT_W    = 2;
    localparam int VAL_W    = 64;
    localparam int ST_W     = 2;
    localparam int CNT_W    = 32;
    localparam int M_DATA_W = VAL_W + 4 * CNT_W;

    // Action codes carried in s_tuser
    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    // Status codes carried in m_tuser
    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_NULL  = 2'd3
    } status_t;

    // Commands into the cell row
    typedef struct packed {
        logic push;
        logic pop;
    } chain_ctl_t;

    // Occupancy flags out of the cell row
    typedef struct packed {
        logic empty;
        logic full;
    } chain_sts_t;

    // Counter commands
    typedef struct packed {
        logic inc_push;
        logic inc_pop;
        logic inc_full;
        logic inc_empty;
        logic clear;
    } stat_ctl_t;

    // Counter values
    typedef struct packed {
        logic [CNT_W-1:0] empty_cnt;
        logic [CNT_W-1:0] full_cnt;
        logic [CNT_W-1:0] pop_cnt;
        logic [CNT_W-1:0] push_cnt;
    } stat_cnt_t;

endpackage

`default_nettype wire

### sv/rfs_cell.sv
// One storage cell of the FIFO row: a data word and its occupied flag.
// Depends on rfs_pkg.
`default_nettype none

module rfs_cell
    import rfs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire chain_ctl_t       ctl,
    input  wire logic [VAL_W-1:0] push_data,
    input  wire logic             prev_valid,   // cell nearer the head is occupied
    input  wire logic             nbr_valid,    // cell farther from the head
    input  wire logic [VAL_W-1:0] nbr_value,
    output logic                  valid,
    output logic [VAL_W-1:0]      value
);

    logic             valid_reg, valid_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic             take_push;

    // A push lands in the first free cell behind the occupied ones
    assign take_push = ctl.push && !valid_reg && prev_valid;

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctl.pop) begin
            // shift one place toward the head
            valid_next = nbr_valid;
            value_next = nbr_value;
        end else if (take_push) begin
            valid_next = 1'b1;
            value_next = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // data word, no reset needed
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

### sv/rfs_chain.sv
// Row of FIFO cells; the head cell holds the oldest word.
// Depends on rfs_pkg and rfs_cell.
`default_nettype none

module rfs_chain
    import rfs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire chain_ctl_t       ctl,
    input  wire logic [VAL_W-1:0] push_data,
    output chain_sts_t            sts,
    output logic [VAL_W-1:0]      head_value
);

    logic [NUM_CELLS-1:0] valid_w;
    logic [VAL_W-1:0]     value_w [NUM_CELLS];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
            logic             prev_v;
            logic             nbr_v;
            logic [VAL_W-1:0] nbr_d;

            // head cell always sees an occupied predecessor
            if (gi == 0) begin : g_head
                assign prev_v = 1'b1;
            end else begin : g_body
                assign prev_v = valid_w[gi-1];
            end

            // tail cell shifts in an empty word on a pop
            if (gi == NUM_CELLS - 1) begin : g_tail
                assign nbr_v = 1'b0;
                assign nbr_d = '0;
            end else begin : g_link
                assign nbr_v = valid_w[gi+1];
                assign nbr_d = value_w[gi+1];
            end

            rfs_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .push_data  (push_data),
                .prev_valid (prev_v),
                .nbr_valid  (nbr_v),
                .nbr_value  (nbr_d),
                .valid      (valid_w[gi]),
                .value      (value_w[gi])
            );
        end
    endgenerate

    // occupancy is a thermometer code from the head
    assign sts.empty  = !valid_w[0];
    assign sts.full   = valid_w[NUM_CELLS-1];
    assign head_value = value_w[0];

endmodule

`default_nettype wire

### sv/rfs_stats.sv
// Four wrapping statistics counters with a common clear.
// Depends on rfs_pkg.
`default_nettype none

module rfs_stats
    import rfs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire stat_ctl_t ctl,
    output stat_cnt_t      cnt
);

    stat_cnt_t cnt_reg, cnt_next;

    always_comb begin
        cnt_next = cnt_reg;
        if (ctl.clear) begin
            cnt_next = '0;
        end else begin
            if (ctl.inc_push)  cnt_next.push_cnt  = cnt_reg.push_cnt  + CNT_W'(1);
            if (ctl.inc_pop)   cnt_next.pop_cnt   = cnt_reg.pop_cnt   + CNT_W'(1);
            if (ctl.inc_full)  cnt_next.full_cnt  = cnt_reg.full_cnt  + CNT_W'(1);
            if (ctl.inc_empty) cnt_next.empty_cnt = cnt_reg.empty_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign cnt = cnt_reg;

endmodule

`default_nettype wire

### sv/ring_fifo_with_statistics_core.sv
// Top level of the ring FIFO with statistics counters.
// Depends on rfs_pkg, rfs_chain (rfs_cell), rfs_stats and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Queue of up to 15 64-bit words (a 16-slot ring with one slot kept free) built
// as a row of cells that shift toward the head on each pop. Each input word is
// a push, a pop or a counter clear, selected by s_tuser; each one yields
// exactly one result word carrying a status code, the popped word and the four
// statistics counters as they stand after the action. An input word is taken
// in every cycle in which the output register is empty or being drained, so
// the block runs at one word per clock unless m_tready stalls it; the result
// appears in the cycle after acceptance, with the cell row and output register
// updated together. Pushing zero gets a null status and changes nothing.
module ring_fifo_with_statistics_core
    import rfs_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [VAL_W-1:0]    s_tdata,   // [63:0] entry_value
    input  wire logic [ACT_W-1:0]    s_tuser,   // [1:0] action
    // result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // [63:0] popped_value, [95:64] push_count,
                                                // [127:96] pop_count, [159:128] full_count,
                                                // [191:160] empty_count
    output logic [ST_W-1:0]          m_tuser    // [1:0] status
);

    logic             accept;
    chain_ctl_t       ch_ctl;
    chain_sts_t       ch_sts;
    logic [VAL_W-1:0] head_value;
    stat_ctl_t        st_ctl;
    stat_cnt_t        cnt;

    status_t          status_reg, status_next;
    logic [VAL_W-1:0] popped_reg, popped_next;
    logic             out_valid_reg, out_valid_next;

    // take a word whenever the output register is free or draining
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // action decode
    always_comb begin
        ch_ctl      = '0;
        st_ctl      = '0;
        status_next = ST_DONE;
        popped_next = '0;
        case (action_t'(s_tuser))
            ACT_PUSH: begin
                if (s_tdata == '0) begin
                    status_next = ST_NULL;
                end else if (ch_sts.full) begin
                    status_next     = ST_FULL;
                    st_ctl.inc_full = accept;
                end else begin
                    ch_ctl.push     = accept;
                    st_ctl.inc_push = accept;
                end
            end
            ACT_POP: begin
                if (ch_sts.empty) begin
                    status_next      = ST_EMPTY;
                    st_ctl.inc_empty = accept;
                end else begin
                    popped_next    = head_value;
                    ch_ctl.pop     = accept;
                    st_ctl.inc_pop = accept;
                end
            end
            ACT_CLEAR: begin
                st_ctl.clear = accept;
            end
            default: begin
                // unused code: no state change
            end
        endcase
    end

    rfs_chain u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ch_ctl),
        .push_data  (s_tdata),
        .sts        (ch_sts),
        .head_value (head_value)
    );

    rfs_stats u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (st_ctl),
        .cnt     (cnt)
    );

    // output register valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload; counters change only on accept, so they track this word
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            popped_reg <= popped_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {cnt.empty_cnt, cnt.full_cnt, cnt.pop_cnt, cnt.push_cnt, popped_reg};

    // checks
    `RFS_NEVER(a_full_and_empty, aclk, aresetn, ch_sts.full && ch_sts.empty)
    `RFS_ASSERT(a_pop_nonzero, aclk, aresetn, (ch_ctl.pop |=> popped_reg != '0))
    `RFS_ASSERT(a_push_count, aclk, aresetn, (ch_ctl.push |=> cnt.push_cnt == $past(cnt.push_cnt) + CNT_W'(1)))

endmodule

`default_nettype wire
